/* src/e2r_pkg.sv */
`default_nettype none
package e2r_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int FRAC_BITS    = 14;
    localparam int ELEM_BITS    = 16;
    localparam int AXIS_BITS    = 2;
    localparam int CFG_IDX_BITS = 2;
    localparam int CORDIC_STEPS = 30;
    localparam int CW           = 34;  // cordic x/y width, 30 fraction bits
    localparam int ZW           = 33;  // residual angle width, 2^32 per turn
    localparam int PW           = 36;  // product accumulation width

    typedef enum logic [AXIS_BITS-1:0] {
        AX_X   = 2'd0,
        AX_Y   = 2'd1,
        AX_Z   = 2'd2,
        AX_BAD = 2'd3
    } axis_t;

    localparam logic [CFG_IDX_BITS-1:0] REG_AXIS_FIRST  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_AXIS_SECOND = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_AXIS_THIRD  = 2'd2;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef logic signed [ELEM_BITS-1:0] elem_t;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] angle_first;
        logic signed [ANGLE_BITS-1:0] angle_second;
        logic signed [ANGLE_BITS-1:0] angle_third;
    } angles_t;

    typedef struct packed {
        elem_t elem_r0c0;
        elem_t elem_r0c1;
        elem_t elem_r0c2;
        elem_t elem_r1c0;
        elem_t elem_r1c1;
        elem_t elem_r1c2;
        elem_t elem_r2c0;
        elem_t elem_r2c1;
        elem_t elem_r2c2;
        logic  sequence_fallback;
    } matrix_t;

    function automatic logic signed [ZW-1:0] atan_turns(input int i);
        logic [31:0] t;
        case (i)
            0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
            3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
            6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
            9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
            12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
            15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
            18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
            21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
            24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
            27: t = 32'h00000005; 28: t = 32'h00000003; 29: t = 32'h00000001;
            default: t = 32'h0;
        endcase
        return $signed({1'b0, t});
    endfunction

    // round with half up, then clamp to +-1.0
    function automatic logic signed [FRAC_BITS+1:0] round_sat_cordic(
        input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        logic signed [CW-1:0] one;
        r   = (v + (CW'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        one = CW'(1) <<< FRAC_BITS;
        if (r > one)       r = one;
        else if (r < -one) r = -one;
        return r[FRAC_BITS+1:0];
    endfunction

    function automatic logic signed [FRAC_BITS+1:0] round_sat_prod(
        input logic signed [PW-1:0] v);
        logic signed [PW-1:0] r;
        logic signed [PW-1:0] one;
        r   = (v + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        one = PW'(1) <<< FRAC_BITS;
        if (r > one)       r = one;
        else if (r < -one) r = -one;
        return r[FRAC_BITS+1:0];
    endfunction

endpackage
`default_nettype wire

/* src/e2r_if.sv */
`default_nettype none
interface e2r_angles_if;
    logic             valid;
    logic             ready;
    e2r_pkg::angles_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface e2r_matrix_if;
    logic             valid;
    logic             ready;
    e2r_pkg::matrix_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/e2r_sincos.sv */
`default_nettype none
module e2r_sincos (
    input  wire logic                                   clk,
    input  wire logic                                   en,
    input  wire logic signed [e2r_pkg::ANGLE_BITS-1:0]  angle,
    output logic signed [e2r_pkg::FRAC_BITS+1:0]        cos_out,
    output logic signed [e2r_pkg::FRAC_BITS+1:0]        sin_out
);
    import e2r_pkg::*;

    localparam int N = CORDIC_STEPS;

    // pipeline stage k holds state before rotation step k
    logic signed [CW-1:0] x_reg [N+1];
    logic signed [CW-1:0] y_reg [N+1];
    logic signed [ZW-1:0] z_reg [N+1];
    logic                 flip_reg [N+1];
    logic signed [FRAC_BITS+1:0] cos_reg, sin_reg;

    logic [31:0]          u0, u1;
    logic signed [ZW-1:0] z0;
    logic                 fl0;

    always_comb
    begin
        u0  = {angle, {(32-ANGLE_BITS){1'b0}}};
        fl0 = ($signed(u0) > 32'sh40000000) || ($signed(u0) < -32'sh40000000);
        u1  = fl0 ? (u0 ^ 32'h80000000) : u0;
        z0  = ZW'($signed(u1));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= z0;
            flip_reg[0] <= fl0;
            for (int i = 0; i < N; i++)
            begin
                if (!z_reg[i][ZW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_turns(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_turns(i);
                end
                flip_reg[i+1] <= flip_reg[i];
            end
            cos_reg <= flip_reg[N] ? -round_sat_cordic(x_reg[N]) : round_sat_cordic(x_reg[N]);
            sin_reg <= flip_reg[N] ? -round_sat_cordic(y_reg[N]) : round_sat_cordic(y_reg[N]);
        end
    end

    assign cos_out = cos_reg;
    assign sin_out = sin_reg;
endmodule
`default_nettype wire

/* src/euler_to_rotation_matrix.sv */
`default_nettype none
// Euler angles to 3x3 rotation matrix, R = R(axis_first)*R(axis_second)*R(axis_third),
// elements in Q2.14. Fully pipelined: one angle triple is taken every cycle and its
// matrix appears at the output after one entry stage, a 30-stage cordic, rounding,
// then two 3x3 products of two stages each, the last one driving the output; a
// stalled output freezes the whole pipeline. Axis registers are sampled per item on
// entry, so they may be rewritten while idle. Any axis code 3 selects ZYX and sets
// sequence_fallback.
module euler_to_rotation_matrix (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    e2r_angles_if.sink                             in_ch,
    e2r_matrix_if.source                           out_ch,
    input  wire logic                              cfg_we,
    input  wire logic [e2r_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [e2r_pkg::AXIS_BITS-1:0]     cfg_data
);
    import e2r_pkg::*;

    localparam int CD    = CORDIC_STEPS + 2;    // entry..rounded sin/cos
    localparam int DEPTH = CD + 4;
    localparam int EW    = FRAC_BITS + 2;

    typedef logic signed [EW-1:0] e_t;
    typedef e_t mat_t [3][3];

    axis_t axis_first_reg, axis_second_reg, axis_third_reg;
    logic  en;
    logic  valid_reg [DEPTH];

    // axis path alongside cordic
    axis_t a1_reg [CD], a2_reg [CD], a3_reg [CD];
    logic  bad_reg [CD+3];

    e_t   c1, s1, c2, s2, c3, s3;
    mat_t m1, m2, m3;
    mat_t m3_reg, m3b_reg;
    logic signed [PW-1:0] p1_reg [3][3][3];
    mat_t t_reg;
    logic signed [PW-1:0] p2_reg [3][3][3];
    mat_t r_reg;
    logic bad_out_reg;

    assign en          = !valid_reg[DEPTH-1] || out_ch.ready;
    assign in_ch.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_first_reg  <= AX_Z;
            axis_second_reg <= AX_Y;
            axis_third_reg  <= AX_X;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_AXIS_FIRST:  axis_first_reg  <= axis_t'(cfg_data);
                REG_AXIS_SECOND: axis_second_reg <= axis_t'(cfg_data);
                REG_AXIS_THIRD:  axis_third_reg  <= axis_t'(cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++) valid_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_ch.valid;
            for (int i = 1; i < DEPTH; i++) valid_reg[i] <= valid_reg[i-1];
        end
    end

    e2r_sincos u_sc1 (.clk, .en, .angle(in_ch.data.angle_first),
                      .cos_out(c1), .sin_out(s1));
    e2r_sincos u_sc2 (.clk, .en, .angle(in_ch.data.angle_second),
                      .cos_out(c2), .sin_out(s2));
    e2r_sincos u_sc3 (.clk, .en, .angle(in_ch.data.angle_third),
                      .cos_out(c3), .sin_out(s3));

    function automatic mat_t elementary(input axis_t ax, input e_t c, input e_t s);
        mat_t m;
        e_t   one;
        one = e_t'(1) <<< FRAC_BITS;
        for (int r = 0; r < 3; r++)
            for (int k = 0; k < 3; k++)
                m[r][k] = '0;
        case (ax)
            AX_X:
            begin
                m[0][0] = one; m[1][1] = c; m[1][2] = -s; m[2][1] = s; m[2][2] = c;
            end
            AX_Y:
            begin
                m[1][1] = one; m[0][0] = c; m[0][2] = s; m[2][0] = -s; m[2][2] = c;
            end
            default:
            begin
                m[2][2] = one; m[0][0] = c; m[0][1] = -s; m[1][0] = s; m[1][1] = c;
            end
        endcase
        return m;
    endfunction

    always_comb
    begin
        m1 = elementary(a1_reg[CD-1], c1, s1);
        m2 = elementary(a2_reg[CD-1], c2, s2);
        m3 = elementary(a3_reg[CD-1], c3, s3);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (axis_first_reg == AX_BAD || axis_second_reg == AX_BAD
                || axis_third_reg == AX_BAD)
            begin
                a1_reg[0]  <= AX_Z;
                a2_reg[0]  <= AX_Y;
                a3_reg[0]  <= AX_X;
                bad_reg[0] <= 1'b1;
            end
            else
            begin
                a1_reg[0]  <= axis_first_reg;
                a2_reg[0]  <= axis_second_reg;
                a3_reg[0]  <= axis_third_reg;
                bad_reg[0] <= 1'b0;
            end
            for (int i = 1; i < CD; i++)
            begin
                a1_reg[i] <= a1_reg[i-1];
                a2_reg[i] <= a2_reg[i-1];
                a3_reg[i] <= a3_reg[i-1];
            end
            for (int i = 1; i < CD + 3; i++) bad_reg[i] <= bad_reg[i-1];

            // first product: partial terms, then round
            for (int r = 0; r < 3; r++)
                for (int j = 0; j < 3; j++)
                    for (int k = 0; k < 3; k++)
                        p1_reg[r][j][k] <= PW'(m1[r][k]) * PW'(m2[k][j]);
            m3_reg <= m3;
            for (int r = 0; r < 3; r++)
                for (int j = 0; j < 3; j++)
                    t_reg[r][j] <= round_sat_prod(p1_reg[r][j][0] + p1_reg[r][j][1]
                                                  + p1_reg[r][j][2]);
            m3b_reg <= m3_reg;
            for (int r = 0; r < 3; r++)
                for (int j = 0; j < 3; j++)
                    for (int k = 0; k < 3; k++)
                        p2_reg[r][j][k] <= PW'(t_reg[r][k]) * PW'(m3b_reg[k][j]);
            for (int r = 0; r < 3; r++)
                for (int j = 0; j < 3; j++)
                    r_reg[r][j] <= round_sat_prod(p2_reg[r][j][0] + p2_reg[r][j][1]
                                                  + p2_reg[r][j][2]);
            bad_out_reg <= bad_reg[CD+2];
        end
    end

    assign out_ch.valid                  = valid_reg[DEPTH-1];
    assign out_ch.data.elem_r0c0         = ELEM_BITS'(r_reg[0][0]);
    assign out_ch.data.elem_r0c1         = ELEM_BITS'(r_reg[0][1]);
    assign out_ch.data.elem_r0c2         = ELEM_BITS'(r_reg[0][2]);
    assign out_ch.data.elem_r1c0         = ELEM_BITS'(r_reg[1][0]);
    assign out_ch.data.elem_r1c1         = ELEM_BITS'(r_reg[1][1]);
    assign out_ch.data.elem_r1c2         = ELEM_BITS'(r_reg[1][2]);
    assign out_ch.data.elem_r2c0         = ELEM_BITS'(r_reg[2][0]);
    assign out_ch.data.elem_r2c1         = ELEM_BITS'(r_reg[2][1]);
    assign out_ch.data.elem_r2c2         = ELEM_BITS'(r_reg[2][2]);
    assign out_ch.data.sequence_fallback = bad_out_reg;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid)
        else $error("output beat dropped under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_ch.valid |-> in_ch.ready)
        else $error("input stalled with empty output");
    a_fallback: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.data.sequence_fallback |-> bad_out_reg)
        else $error("fallback flag mismatch");
endmodule
`default_nettype wire
